>>> sv/srd_pkg.sv
// types and constants shared by the sprite run-length decoder
package srd_pkg;

   typedef enum logic [2:0] {
      PH_TLO = 3'd0,
      PH_THI = 3'd1,
      PH_CLO = 3'd2,
      PH_CHI = 3'd3,
      PH_PIX = 3'd4
   } phase_type;

   typedef struct packed {
      logic        last_run;
      logic [7:0]  alpha;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [10:0] pixel_count;
      logic [9:0]  first_pixel;
   } run_type;

   typedef struct packed {
      logic    run_valid;
      run_type run;
      logic    close_valid;
      run_type close;
   } emit_type;

   localparam logic CSR_PIXEL_HAS_ALPHA = 1'b0;
   localparam logic CSR_OUTPUT_MODE     = 1'b1;

   localparam logic [7:0] FILL_GREY    = 8'h11;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

endpackage

>>> sv/srd_parser.sv
// stream parser state and per-byte run descriptor generation
module srd_parser
   import srd_pkg::*;
#(
   parameter int SPRITE_SIDE = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic       pixel_has_alpha,
   input  logic       output_mode,
   output emit_type   emit
);

   localparam int FRAME = SPRITE_SIDE * SPRITE_SIDE;
   localparam int WP_W  = $clog2(FRAME + 1);
   localparam logic [WP_W-1:0] FRAME_V = WP_W'(FRAME);

   phase_type       phase_ff, phase_in;
   logic [7:0]      low_hold_ff, low_hold_in;
   logic [15:0]     colored_left_ff, colored_left_in;
   logic [WP_W-1:0] wp_ff, wp_in;
   logic [1:0]      byte_idx_ff, byte_idx_in;
   logic [7:0]      red_ff, red_in;
   logic [7:0]      green_ff, green_in;
   logic [7:0]      blue_ff, blue_in;

   logic [15:0]     count16;
   logic [15:0]     room16;
   logic [15:0]     clip16;
   logic [WP_W-1:0] room;
   logic [WP_W-1:0] wp_mid;
   logic [WP_W-1:0] close_cnt;
   logic [7:0]      fill;
   logic            pix_done;
   logic [15:0]     left_dec;

   always_comb begin
      fill      = output_mode ? 8'h00 : FILL_GREY;
      count16   = {data_byte, low_hold_ff};
      room      = FRAME_V - wp_ff;
      room16    = 16'(room);
      clip16    = (count16 < room16) ? count16 : room16;
      pix_done  = (byte_idx_ff == 2'd3) || (byte_idx_ff == 2'd2 && !pixel_has_alpha);
      left_dec  = colored_left_ff - 16'd1;

      phase_in        = phase_ff;
      low_hold_in     = low_hold_ff;
      colored_left_in = colored_left_ff;
      wp_in           = wp_ff;
      byte_idx_in     = byte_idx_ff;
      red_in          = red_ff;
      green_in        = green_ff;
      blue_in         = blue_ff;

      emit = '0;
      emit.run.red   = fill;
      emit.run.green = fill;
      emit.run.blue  = fill;

      if (wp_ff < FRAME_V) begin
         case (phase_ff)
            PH_THI: begin
               if (clip16 != 16'd0) begin
                  emit.run_valid        = 1'b1;
                  emit.run.first_pixel  = 10'(wp_ff);
                  emit.run.pixel_count  = 11'(clip16);
                  wp_in                 = wp_ff + WP_W'(clip16);
               end
               phase_in = PH_CLO;
            end
            PH_CLO: begin
               low_hold_in = data_byte;
               phase_in    = PH_CHI;
            end
            PH_CHI: begin
               colored_left_in = count16;
               byte_idx_in     = 2'd0;
               phase_in        = (count16 != 16'd0) ? PH_PIX : PH_TLO;
            end
            PH_PIX: begin
               case (byte_idx_ff)
                  2'd0:    red_in   = data_byte;
                  2'd1:    green_in = data_byte;
                  2'd2:    blue_in  = data_byte;
                  default: ;
               endcase
               if (pix_done) begin
                  emit.run_valid       = 1'b1;
                  emit.run.first_pixel = 10'(wp_ff);
                  emit.run.pixel_count = 11'd1;
                  emit.run.red         = red_in;
                  emit.run.green       = green_in;
                  emit.run.blue        = blue_in;
                  emit.run.alpha       = output_mode ?
                                         (pixel_has_alpha ? data_byte : ALPHA_OPAQUE) : 8'h00;
                  wp_in                = wp_ff + WP_W'(1);
                  colored_left_in      = left_dec;
                  byte_idx_in          = 2'd0;
                  if (left_dec == 16'd0) begin
                     phase_in = PH_TLO;
                  end
               end else begin
                  byte_idx_in = byte_idx_ff + 2'd1;
               end
            end
            default: begin
               low_hold_in = data_byte;
               phase_in    = PH_THI;
            end
         endcase
      end

      wp_mid    = wp_in;
      close_cnt = (wp_mid < FRAME_V) ? FRAME_V - wp_mid : '0;

      emit.close.first_pixel = (close_cnt != '0) ? 10'(wp_mid) : 10'd0;
      emit.close.pixel_count = 11'(close_cnt);
      emit.close.red         = fill;
      emit.close.green       = fill;
      emit.close.blue        = fill;
      emit.close.alpha       = 8'h00;
      emit.close.last_run    = 1'b1;
      emit.close_valid       = last_byte;

      if (last_byte) begin
         phase_in        = PH_TLO;
         low_hold_in     = 8'h00;
         colored_left_in = 16'd0;
         wp_in           = '0;
         byte_idx_in     = 2'd0;
         red_in          = 8'h00;
         green_in        = 8'h00;
         blue_in         = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TLO;
         low_hold_ff     <= 8'h00;
         colored_left_ff <= 16'd0;
         wp_ff           <= '0;
         byte_idx_ff     <= 2'd0;
         red_ff          <= 8'h00;
         green_ff        <= 8'h00;
         blue_ff         <= 8'h00;
      end else if (step) begin
         phase_ff        <= phase_in;
         low_hold_ff     <= low_hold_in;
         colored_left_ff <= colored_left_in;
         wp_ff           <= wp_in;
         byte_idx_ff     <= byte_idx_in;
         red_ff          <= red_in;
         green_ff        <= green_in;
         blue_ff         <= blue_in;
      end
   end

endmodule

>>> sv/srd_run_fifo.sv
// small result queue taking up to two run descriptors per cycle
module srd_run_fifo
   import srd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_a,
   input  run_type              data_a,
   input  logic                 push_b,
   input  run_type              data_b,
   output logic                 out_valid,
   input  logic                 out_ready,
   output run_type              out_data,
   output logic [OUT_CNT_W-1:0] level
);

   run_type                slot_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;
   logic                   two;
   logic                   any;
   run_type                first_data;
   logic [OUT_PTR_W-1:0]   wr_next;

   always_comb begin
      pop        = (count_ff != '0) && out_ready;
      two        = push_a && push_b;
      any        = push_a || push_b;
      first_data = push_a ? data_a : data_b;
      wr_next    = wr_ptr_ff + OUT_PTR_W'(1);
      wr_ptr_in  = wr_ptr_ff + (two ? OUT_PTR_W'(2) : (any ? OUT_PTR_W'(1) : '0));
      rd_ptr_in  = pop ? rd_ptr_ff + OUT_PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + (two ? OUT_CNT_W'(2) : (any ? OUT_CNT_W'(1) : '0))
                   - (pop ? OUT_CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (any) begin
         slot_ff[wr_ptr_ff] <= first_data;
      end
      if (two) begin
         slot_ff[wr_next] <= data_b;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign level     = count_ff;

endmodule

>>> sv/sprite_rle_decoder_top.sv
// top level of the run-length sprite decoder
//
// req_ carries the compressed sprite stream, one byte per transfer, with
// req_tlast on the final byte. rsp_ carries run descriptors: each finished
// transparent run and each finished colored pixel, plus one closing run
// (rsp_tlast high) that fills the rest of the frame after the final byte.
// csr_ writes pixel_has_alpha (index 0) and output_mode (index 1); write
// only while no bytes are in flight.
// A byte is taken into an input register, then decoded once the result
// queue has room, and its runs are queued for rsp_. One byte is taken per
// cycle while the queue has room; a byte that ends the stream with a colored
// pixel yields two runs, which the result queue absorbs while the next bytes
// keep flowing.
// Reset clears the parser, the queue and the registers (pixel_has_alpha 0,
// output_mode 1). When rsp_tready is low the queue fills and req_tready
// drops once fewer than two queue slots are free.
module sprite_rle_decoder_top
   import srd_pkg::*;
#(
   parameter int SPRITE_SIDE = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // first_pixel, pixel_count, red, green, blue, alpha
   output logic        rsp_tlast,   // last_run
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic        csr_wdata
);

   localparam int FRAME = SPRITE_SIDE * SPRITE_SIDE;

   logic                 has_alpha_ff;
   logic                 mode_ff;
   logic                 hold_valid_ff, hold_valid_in;
   logic [7:0]           hold_byte_ff;
   logic                 hold_last_ff;
   logic                 proceed;
   logic                 room_ok;
   logic [OUT_CNT_W-1:0] level;
   emit_type             emit;
   run_type              out_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_alpha_ff <= 1'b0;
         mode_ff      <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PIXEL_HAS_ALPHA: has_alpha_ff <= csr_wdata;
            CSR_OUTPUT_MODE:     mode_ff      <= csr_wdata;
            default:             ;
         endcase
      end
   end

   always_comb begin
      room_ok       = (level <= OUT_CNT_W'(OUT_DEPTH - 2));
      proceed       = hold_valid_ff && room_ok;
      req_tready    = !hold_valid_ff || proceed;
      hold_valid_in = (req_tvalid && req_tready) ? 1'b1 : (proceed ? 1'b0 : hold_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         hold_byte_ff <= req_tdata;
         hold_last_ff <= req_tlast;
      end
   end

   srd_parser #(
      .SPRITE_SIDE(SPRITE_SIDE)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (proceed),
      .data_byte       (hold_byte_ff),
      .last_byte       (hold_last_ff),
      .pixel_has_alpha (has_alpha_ff),
      .output_mode     (mode_ff),
      .emit            (emit)
   );

   srd_run_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_a    (proceed && emit.run_valid),
      .data_a    (emit.run),
      .push_b    (proceed && emit.close_valid),
      .data_b    (emit.close),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_run),
      .level     (level)
   );

   assign rsp_tdata = {3'b000, out_run.alpha, out_run.blue, out_run.green, out_run.red,
                       out_run.pixel_count, out_run.first_pixel};
   assign rsp_tlast = out_run.last_run;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= OUT_CNT_W'(OUT_DEPTH))
      else $error("result queue overflow");

   a_hold_kept: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !proceed |=> hold_valid_ff && $stable(hold_byte_ff)
         && $stable(hold_last_ff))
      else $error("held byte lost while queue full");

   a_close_fills_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (FRAME > 1024)
         || (out_run.pixel_count == 11'd0 && out_run.first_pixel == 10'd0)
         || (12'(out_run.first_pixel) + 12'(out_run.pixel_count) == 12'(FRAME)))
      else $error("closing run does not end at frame size");

endmodule
